// ===== rtl/core/sra_pkg.sv =====
// Shared types and constants for the tick-paced SPI mode-0 register master.
// Used by sra_step and spi_register_access_master; no other dependencies.
package sra_pkg;

    // Write requests carry this flag in the address byte
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    // Half period after reset, in ticks
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_FINAL = 3'd3,
        PH_TAIL  = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  tick_timer;
        logic [2:0]  bit_position;
        logic [7:0]  bytes_left;
        logic [7:0]  tx_shift;
        logic [7:0]  rx_shift;
        logic        read_mode;
        logic        in_address_byte;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:           PH_IDLE,
        tick_timer:      8'd0,
        bit_position:    3'd0,
        bytes_left:      8'd0,
        tx_shift:        8'd0,
        rx_shift:        8'd0,
        read_mode:       1'b0,
        in_address_byte: 1'b0
    };

    // One tick request
    typedef struct packed {
        logic       start_req;
        logic       is_read;
        logic [6:0] address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       miso;
    } t_item;

    // Line levels and strobes after one tick
    typedef struct packed {
        logic       nss;
        logic       sck;
        logic       mosi;
        logic       take_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       busy_res;
        logic       done_res;
    } t_result;

endpackage

// ===== rtl/core/sra_step.sv =====
// Next-state and output logic for one tick of the SPI register master.
// Depends on sra_pkg for the state, request and result types.
module sra_step (
    input  sra_pkg::t_state  i_state,
    input  sra_pkg::t_item   i_item,
    input  logic [7:0]       i_half_period,
    output sra_pkg::t_state  o_state,
    output sra_pkg::t_result o_result
);

    logic [7:0] reload;

    // Reload value for the hold timer; a zero half period acts as one
    assign reload = (i_half_period == 8'd0) ? 8'd0 : i_half_period - 8'd1;

    // Advance the transfer by one tick
    always_comb begin
        logic more;
        more     = 1'b0;
        o_state  = i_state;
        o_result = '0;
        case (i_state.phase)
            sra_pkg::PH_IDLE: begin
                if (i_item.start_req) begin
                    o_state.read_mode       = i_item.is_read;
                    o_state.in_address_byte = 1'b1;
                    o_state.bytes_left      = i_item.byte_count;
                    o_state.tx_shift        = {1'b0, i_item.address}
                                            | (i_item.is_read ? 8'd0 : sra_pkg::WRITE_FLAG);
                    o_state.rx_shift        = 8'd0;
                    o_state.bit_position    = 3'd0;
                    o_state.phase           = sra_pkg::PH_LOW;
                    o_state.tick_timer      = reload;
                end
            end
            sra_pkg::PH_LOW: begin
                if (i_state.tick_timer != 8'd0) begin
                    o_state.tick_timer = i_state.tick_timer - 8'd1;
                end else begin
                    o_state.phase      = sra_pkg::PH_HIGH;
                    o_state.tick_timer = reload;
                end
            end
            sra_pkg::PH_HIGH: begin
                if (i_state.tick_timer != 8'd0) begin
                    o_state.tick_timer = i_state.tick_timer - 8'd1;
                end else begin
                    // Sample MISO on the last high tick of a read data byte
                    if (!i_state.in_address_byte && i_state.read_mode) begin
                        o_state.rx_shift = {i_state.rx_shift[6:0], i_item.miso};
                    end
                    o_state.tx_shift   = {i_state.tx_shift[6:0], 1'b0};
                    o_state.tick_timer = reload;
                    if (i_state.bit_position != 3'd7) begin
                        o_state.bit_position = i_state.bit_position + 3'd1;
                        o_state.phase        = sra_pkg::PH_LOW;
                    end else begin
                        o_state.bit_position = 3'd0;
                        if (i_state.in_address_byte) begin
                            o_state.in_address_byte = 1'b0;
                        end else begin
                            if (i_state.read_mode) begin
                                o_result.read_valid = 1'b1;
                                o_result.read_data  = o_state.rx_shift;
                            end
                            o_state.bytes_left = i_state.bytes_left - 8'd1;
                        end
                        more = (o_state.bytes_left != 8'd0);
                        if (more) begin
                            if (i_state.read_mode) begin
                                o_state.tx_shift = 8'd0;
                            end else begin
                                o_state.tx_shift   = i_item.write_data;
                                o_result.take_byte = 1'b1;
                            end
                            o_state.phase = sra_pkg::PH_LOW;
                        end else begin
                            o_state.phase = sra_pkg::PH_FINAL;
                        end
                    end
                end
            end
            sra_pkg::PH_FINAL: begin
                if (i_state.tick_timer != 8'd0) begin
                    o_state.tick_timer = i_state.tick_timer - 8'd1;
                end else begin
                    o_state.phase      = sra_pkg::PH_TAIL;
                    o_state.tick_timer = reload;
                end
            end
            sra_pkg::PH_TAIL: begin
                if (i_state.tick_timer != 8'd0) begin
                    o_state.tick_timer = i_state.tick_timer - 8'd1;
                end else begin
                    o_state.phase     = sra_pkg::PH_IDLE;
                    o_result.done_res = 1'b1;
                end
            end
            default: begin
                // Drop back to idle without a done strobe
                o_state.phase           = sra_pkg::PH_IDLE;
                o_state.tick_timer      = 8'd0;
                o_state.bit_position    = 3'd0;
                o_state.bytes_left      = 8'd0;
                o_state.tx_shift        = 8'd0;
                o_state.in_address_byte = 1'b0;
            end
        endcase

        // Line levels follow the updated state
        o_result.nss      = (o_state.phase == sra_pkg::PH_IDLE)
                         || (o_state.phase == sra_pkg::PH_TAIL);
        o_result.sck      = (o_state.phase == sra_pkg::PH_HIGH);
        o_result.mosi     = o_state.tx_shift[7];
        o_result.busy_res = (o_state.phase != sra_pkg::PH_IDLE);
    end

endmodule

// ===== rtl/core/spi_register_access_master.sv =====
// Top level of the tick-paced SPI mode-0 register master: input register,
// transfer state, output register and half-period register. Uses sra_pkg, sra_step.
//
//   channel  direction  handshake                  carries
//   in       to block   i_in_valid / o_in_stall    one tick request
//   out      from block o_out_valid / i_out_stall  line levels and strobes
//   cfg      to block   i_cfg_valid / o_cfg_ready  half period in ticks
//
// A request's result is registered before it is presented: the request waits
// in the input register, then the step logic loads the output register. A new
// request is taken every cycle unless the input side stalls; the transfer state
// advances once per request. Reset (synchronous, active low) clears both registers'
// valid flags, the transfer state, and sets the half period to 4.
// A stall on the result side holds the output register and then the input
// register; the input side stalls only when both are occupied.
module spi_register_access_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_start_req,
    input  logic       i_is_read,
    input  logic [6:0] i_address,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_write_data,
    input  logic       i_miso,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_nss,
    output logic       o_sck,
    output logic       o_mosi,
    output logic       o_take_byte,
    output logic       o_read_valid,
    output logic [7:0] o_read_data,
    output logic       o_busy_res,
    output logic       o_done_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic              r_in_valid;
    sra_pkg::t_item    r_item;
    logic              r_out_valid;
    sra_pkg::t_result  r_out;
    sra_pkg::t_state   r_state;
    sra_pkg::t_state   n_state;
    sra_pkg::t_result  n_out;
    logic [7:0]        r_half_period;
    logic              advance;
    logic              in_accept;

    sra_step u_step (
        .i_state       (r_state),
        .i_item        (r_item),
        .i_half_period (r_half_period),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // Move a request forward when the output register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= sra_pkg::STATE_RESET;
            r_half_period <= sra_pkg::HALF_PERIOD_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_half_period <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.start_req  <= i_start_req;
            r_item.is_read    <= i_is_read;
            r_item.address    <= i_address;
            r_item.byte_count <= i_byte_count;
            r_item.write_data <= i_write_data;
            r_item.miso       <= i_miso;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_nss        = r_out.nss;
    assign o_sck        = r_out.sck;
    assign o_mosi       = r_out.mosi;
    assign o_take_byte  = r_out.take_byte;
    assign o_read_valid = r_out.read_valid;
    assign o_read_data  = r_out.read_data;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;

    // SCK only toggles with chip select low
    a_sck_under_nss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_sck && o_nss))
        else $error("sck high while nss high");

    // Done comes with the block back at idle and chip select released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (!o_busy_res && o_nss && !o_sck))
        else $error("done without returning to idle");

    // A byte boundary never brings a write take and a read completion together
    a_take_xor_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_take_byte && o_read_valid))
        else $error("take_byte and read_valid together");

    // Idle always leaves the hold timer expired
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == sra_pkg::PH_IDLE) |-> (r_state.tick_timer == 8'd0))
        else $error("idle with running timer");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for spi_register_access_master: random ticks, shadow SPI master.
// Depends on sra_pkg and the spi_register_access_master RTL; nothing else.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // Two register stages from request to result, plus margin
    localparam int unsigned DRAIN_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_start_req;
    logic       i_is_read;
    logic [6:0] i_address;
    logic [7:0] i_byte_count;
    logic [7:0] i_write_data;
    logic       i_miso;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_nss;
    logic       o_sck;
    logic       o_mosi;
    logic       o_take_byte;
    logic       o_read_valid;
    logic [7:0] o_read_data;
    logic       o_busy_res;
    logic       o_done_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    spi_register_access_master dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_req  (i_start_req),
        .i_is_read    (i_is_read),
        .i_address    (i_address),
        .i_byte_count (i_byte_count),
        .i_write_data (i_write_data),
        .i_miso       (i_miso),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_nss        (o_nss),
        .o_sck        (o_sck),
        .o_mosi       (o_mosi),
        .o_take_byte  (o_take_byte),
        .o_read_valid (o_read_valid),
        .o_read_data  (o_read_data),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow copy of the master's state and half-period register
    sra_pkg::t_phase shadow_phase;
    logic [7:0]      shadow_timer;
    logic [2:0]      shadow_bit;
    logic [7:0]      shadow_left;
    logic [7:0]      shadow_tx;
    logic [7:0]      shadow_rx;
    logic            shadow_read;
    logic            shadow_addr_byte;
    logic [7:0]      shadow_half;

    sra_pkg::t_result expected_lines[$];
    int unsigned      fail_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      stall_left = 0;
    bit               idling_on;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] level_reload();
        return (shadow_half == 8'd0) ? 8'd0 : shadow_half - 8'd1;
    endfunction

    // Advance the shadow master by one tick and produce its line levels
    task automatic predict_tick(input sra_pkg::t_item it, output sra_pkg::t_result res);
        res = '0;
        case (shadow_phase)
            sra_pkg::PH_IDLE: begin
                if (it.start_req) begin
                    shadow_read      = it.is_read;
                    shadow_addr_byte = 1'b1;
                    shadow_left      = it.byte_count;
                    shadow_tx        = {1'b0, it.address}
                                     | (it.is_read ? 8'd0 : sra_pkg::WRITE_FLAG);
                    shadow_rx        = 8'd0;
                    shadow_bit       = 3'd0;
                    shadow_phase     = sra_pkg::PH_LOW;
                    shadow_timer     = level_reload();
                end
            end
            sra_pkg::PH_LOW: begin
                if (shadow_timer != 8'd0) begin
                    shadow_timer = shadow_timer - 8'd1;
                end else begin
                    shadow_phase = sra_pkg::PH_HIGH;
                    shadow_timer = level_reload();
                end
            end
            sra_pkg::PH_HIGH: begin
                if (shadow_timer != 8'd0) begin
                    shadow_timer = shadow_timer - 8'd1;
                end else begin
                    if (!shadow_addr_byte && shadow_read)
                        shadow_rx = {shadow_rx[6:0], it.miso};
                    shadow_tx    = {shadow_tx[6:0], 1'b0};
                    shadow_timer = level_reload();
                    if (shadow_bit != 3'd7) begin
                        shadow_bit   = shadow_bit + 3'd1;
                        shadow_phase = sra_pkg::PH_LOW;
                    end else begin
                        shadow_bit = 3'd0;
                        if (shadow_addr_byte) begin
                            shadow_addr_byte = 1'b0;
                        end else begin
                            if (shadow_read) begin
                                res.read_valid = 1'b1;
                                res.read_data  = shadow_rx;
                            end
                            shadow_left = shadow_left - 8'd1;
                        end
                        if (shadow_left != 8'd0) begin
                            if (shadow_read) begin
                                shadow_tx = 8'd0;
                            end else begin
                                shadow_tx     = it.write_data;
                                res.take_byte = 1'b1;
                            end
                            shadow_phase = sra_pkg::PH_LOW;
                        end else begin
                            shadow_phase = sra_pkg::PH_FINAL;
                        end
                    end
                end
            end
            sra_pkg::PH_FINAL: begin
                if (shadow_timer != 8'd0) begin
                    shadow_timer = shadow_timer - 8'd1;
                end else begin
                    shadow_phase = sra_pkg::PH_TAIL;
                    shadow_timer = level_reload();
                end
            end
            sra_pkg::PH_TAIL: begin
                if (shadow_timer != 8'd0) begin
                    shadow_timer = shadow_timer - 8'd1;
                end else begin
                    shadow_phase = sra_pkg::PH_IDLE;
                    res.done_res = 1'b1;
                end
            end
            default: begin
                shadow_phase     = sra_pkg::PH_IDLE;
                shadow_timer     = 8'd0;
                shadow_bit       = 3'd0;
                shadow_left      = 8'd0;
                shadow_tx        = 8'd0;
                shadow_addr_byte = 1'b0;
            end
        endcase
        res.nss      = (shadow_phase == sra_pkg::PH_IDLE) || (shadow_phase == sra_pkg::PH_TAIL);
        res.sck      = (shadow_phase == sra_pkg::PH_HIGH);
        res.mosi     = shadow_tx[7];
        res.busy_res = (shadow_phase != sra_pkg::PH_IDLE);
    endtask

    function automatic sra_pkg::t_item random_item();
        sra_pkg::t_item it;
        it.start_req  = 1'($urandom_range(0, 1));
        it.is_read    = 1'($urandom_range(0, 1));
        it.address    = 7'($urandom_range(0, 127));
        it.byte_count = 8'($urandom_range(0, 255));
        it.write_data = 8'($urandom_range(0, 255));
        it.miso       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Append one predicted result to the scoreboard
    function automatic void queue_expected(input sra_pkg::t_result res);
        expected_lines = {expected_lines, res};
    endfunction

    // Send one tick request; returns at the edge that accepts it
    task automatic send_tick(input sra_pkg::t_item it);
        sra_pkg::t_result res;
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_req  <= it.start_req;
        i_is_read    <= it.is_read;
        i_address    <= it.address;
        i_byte_count <= it.byte_count;
        i_write_data <= it.write_data;
        i_miso       <= it.miso;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tick(it, res);
        queue_expected(res);
    endtask

    // Hold requests off until every expected result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_period(input logic [7:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_half = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic idle_ticks(input int unsigned count);
        sra_pkg::t_item it;
        repeat (count) begin
            it = random_item();
            it.start_req = 1'b0;
            send_tick(it);
        end
    endtask

    // One transaction from start to done; noise starts while busy are ignored
    task automatic run_transfer(input logic rd, input logic [6:0] addr,
                                input logic [7:0] count);
        sra_pkg::t_item it;
        it = random_item();
        it.start_req  = 1'b1;
        it.is_read    = rd;
        it.address    = addr;
        it.byte_count = count;
        send_tick(it);
        while (shadow_phase != sra_pkg::PH_IDLE) begin
            send_tick(random_item());
        end
    endtask

    task automatic test_idle_lines();
        idle_ticks(3);
    endtask

    // Address byte alone, first at the reset half period
    task automatic test_address_only();
        run_transfer(1'b0, 7'h7F, 8'd0);
        write_half_period(8'd1);
        run_transfer(1'b1, 7'h00, 8'd0);
    endtask

    task automatic test_short_bursts();
        run_transfer(1'b0, 7'h55, 8'd2);
        run_transfer(1'b1, 7'h2A, 8'd1);
    endtask

    task automatic test_zero_half_period();
        write_half_period(8'd0);
        run_transfer(1'b0, 7'h12, 8'd1);
        run_transfer(1'b1, 7'h6D, 8'd0);
    endtask

    // Change the half period while a transfer is under way
    task automatic test_mid_transfer_config();
        sra_pkg::t_item it;
        write_half_period(8'd1);
        it = random_item();
        it.start_req  = 1'b1;
        it.is_read    = 1'b0;
        it.address    = 7'h21;
        it.byte_count = 8'd0;
        send_tick(it);
        repeat (5) send_tick(random_item());
        write_half_period(8'd2);
        while (shadow_phase != sra_pkg::PH_IDLE) begin
            send_tick(random_item());
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] half;
        logic [7:0] count;
        repeat (3) begin
            if ($urandom_range(0, 3) == 0)
                half = 8'($urandom_range(0, 2));
            else
                half = 8'd1;
            write_half_period(half);
            count = 8'($urandom_range(0, 1));
            run_transfer(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), count);
            idle_ticks($urandom_range(0, 2));
        end
    endtask

    // Final stretch: no idling on either side, starts right after done
    task automatic test_back_to_back();
        idling_on = 1'b0;
        write_half_period(8'd1);
        repeat (3) begin
            run_transfer(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                         8'($urandom_range(0, 1)));
        end
    endtask

    // Check each accepted result and pace the result-side stall
    always @(posedge i_clk) begin
        sra_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lines.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = expected_lines.pop_front();
                if (o_nss !== want.nss) begin
                    $error("nss: expected %0d, got %0d", want.nss, o_nss);
                    fail_count++;
                end
                if (o_sck !== want.sck) begin
                    $error("sck: expected %0d, got %0d", want.sck, o_sck);
                    fail_count++;
                end
                if (o_mosi !== want.mosi) begin
                    $error("mosi: expected %0d, got %0d", want.mosi, o_mosi);
                    fail_count++;
                end
                if (o_take_byte !== want.take_byte) begin
                    $error("take_byte: expected %0d, got %0d", want.take_byte, o_take_byte);
                    fail_count++;
                end
                if (o_read_valid !== want.read_valid) begin
                    $error("read_valid: expected %0d, got %0d", want.read_valid, o_read_valid);
                    fail_count++;
                end
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data, o_read_data);
                    fail_count++;
                end
                if (o_busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, o_busy_res);
                    fail_count++;
                end
                if (o_done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, o_done_res);
                    fail_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  = $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_start_req  = 1'b0;
        i_is_read    = 1'b0;
        i_address    = 7'd0;
        i_byte_count = 8'd0;
        i_write_data = 8'd0;
        i_miso       = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'd0;
        idling_on    = 1'b1;

        shadow_phase     = sra_pkg::PH_IDLE;
        shadow_timer     = 8'd0;
        shadow_bit       = 3'd0;
        shadow_left      = 8'd0;
        shadow_tx        = 8'd0;
        shadow_rx        = 8'd0;
        shadow_read      = 1'b0;
        shadow_addr_byte = 1'b0;
        shadow_half      = sra_pkg::HALF_PERIOD_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_lines();
        test_address_only();
        test_short_bursts();
        test_zero_half_period();
        test_mid_transfer_config();
        test_random_traffic();
        test_back_to_back();

        wait_drained();
        if (expected_lines.size() != 0) begin
            $error("%0d results never arrived", expected_lines.size());
        end
        if (fail_count == 0 && expected_lines.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== spi_register_access_master.f =====
rtl/core/sra_pkg.sv
rtl/core/sra_step.sv
rtl/core/spi_register_access_master.sv
bench/tb.sv
